FILE: rtl/core/sefc_pkg.sv
package sefc_pkg;

    // Fixed formats of the gain words and of the filter state.
    localparam int GAIN_WIDTH = 18;
    localparam int GAIN_FRAC = 14;
    localparam int STATE_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    // Configuration register indexes.
    localparam cfg_index_t REG_HP_LEFT = 3'd0;
    localparam cfg_index_t REG_HP_RIGHT = 3'd1;
    localparam cfg_index_t REG_LP_LEFT = 3'd2;
    localparam cfg_index_t REG_LP_RIGHT = 3'd3;
    localparam cfg_index_t REG_LOW_SHELF = 3'd4;
    localparam cfg_index_t REG_HIGH_SHELF = 3'd5;
    localparam cfg_index_t REG_DRIVE_TRIM = 3'd6;
    localparam cfg_index_t REG_MIX_LEVEL = 3'd7;

    // Filter section within one channel; also the low bits of the state index.
    typedef enum logic [1:0] {
        SEC_HP = 2'd0,
        SEC_LP = 2'd1,
        SEC_LS = 2'd2,
        SEC_HS = 2'd3
    } sec_t;

    // Multiplier operand A source.
    typedef enum logic [1:0] {
        A_CUR = 2'd0,
        A_X1 = 2'd1,
        A_Y1 = 2'd2
    } a_sel_t;

    // Multiplier operand B source.
    typedef enum logic [2:0] {
        B_B0 = 3'd0,
        B_B1 = 3'd1,
        B_A1 = 3'd2,
        B_DRIVE = 3'd3,
        B_TRIM = 3'd4,
        B_MIX = 3'd5,
        B_LEVEL = 3'd6
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD = 2'd2
    } acc_op_t;

    // Write-back operation that closes a section or a gain step.
    typedef enum logic [2:0] {
        FIN_NONE = 3'd0,
        FIN_SEC = 3'd1,
        FIN_CLAMP = 3'd2,
        FIN_GAIN = 3'd3,
        FIN_MIX_ADD = 3'd4,
        FIN_OUT = 3'd5
    } fin_op_t;

    // Command bundle from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    load;
        logic    ch;
        sec_t    sec;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t acc_op;
        fin_op_t fin_op;
        logic    publish;
    } sefc_cmd_t;

endpackage

FILE: rtl/core/stereo_enhancer_filter_chain.sv
// The block takes one frame at a time: a new input beat is accepted only when idle,
// once the previous frame has gone to the output register. One shared multiplier runs
// all 32 products of the two channels (filter sections and gain steps) in turn.
// Reset (rst_n, asynchronous, active low) zeroes all configuration registers and
// all filter state, and leaves the block idle with no result pending.
module stereo_enhancer_filter_chain
    import sefc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH = 18
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           write_enable,
    input  cfg_index_t                     write_index,
    input  logic [3*COEF_WIDTH-1:0]        write_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] left_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] right_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] left_result,
    output logic signed [SAMPLE_WIDTH-1:0] right_result
);

    sefc_cmd_t cmd;

    sefc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sefc_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .cmd          (cmd),
        .left_result  (left_result),
        .right_result (right_result)
    );

    // A finished frame is only moved to the output when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid || out_ready))
        else $error("frame published over a pending result beat");

    // A new input beat is never taken while a section or gain step writes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (cmd.fin_op == FIN_NONE))
        else $error("input beat accepted during datapath write-back");

    // Once a frame is taken, the block is busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still ready right after accepting a beat");

    // Publishing a frame raises the output beat on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid)
        else $error("published frame not offered on the output");

endmodule

FILE: rtl/core/sefc_datapath.sv
module sefc_datapath
    import sefc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH = 18
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           write_enable,
    input  cfg_index_t                     write_index,
    input  logic [3*COEF_WIDTH-1:0]        write_data,
    input  logic signed [SAMPLE_WIDTH-1:0] left_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] right_sample,
    input  sefc_cmd_t                      cmd,
    output logic signed [SAMPLE_WIDTH-1:0] left_result,
    output logic signed [SAMPLE_WIDTH-1:0] right_result
);

    localparam int MulWidth = (COEF_WIDTH > GAIN_WIDTH) ? COEF_WIDTH : GAIN_WIDTH;
    localparam int ProdWidth = STATE_WIDTH + MulWidth;
    localparam int AccWidth = ProdWidth + 2;
    localparam int CoefFrac = COEF_WIDTH - 2;
    localparam int CfgWidth = 3 * COEF_WIDTH;
    localparam int SectionCount = 8;

    localparam logic signed [AccWidth-1:0] SecHalf = AccWidth'(1) <<< (CoefFrac - 1);
    localparam logic signed [AccWidth-1:0] GainHalf = AccWidth'(1) <<< (GAIN_FRAC - 1);
    localparam logic signed [AccWidth-1:0] StateMax =
        (AccWidth'(1) <<< (STATE_WIDTH - 1)) - AccWidth'(1);
    localparam logic signed [AccWidth-1:0] StateMin = -(AccWidth'(1) <<< (STATE_WIDTH - 1));
    localparam logic signed [AccWidth-1:0] OneVal = AccWidth'(1) <<< (SAMPLE_WIDTH - 1);
    localparam logic signed [AccWidth-1:0] NegOne = -OneVal;
    localparam logic signed [AccWidth-1:0] OutMax = OneVal - AccWidth'(1);

    localparam logic signed [STATE_WIDTH:0] SumMax = (STATE_WIDTH+1)'(StateMax);
    localparam logic signed [STATE_WIDTH:0] SumMin = (STATE_WIDTH+1)'(StateMin);

    // Configuration registers.
    logic [CfgWidth-1:0]     hp_left_reg, hp_right_reg, lp_left_reg, lp_right_reg;
    logic [CfgWidth-1:0]     low_shelf_reg, high_shelf_reg;
    logic [2*GAIN_WIDTH-1:0] drive_trim_reg, mix_level_reg;

    // Filter state: previous input and output of every section of both channels.
    logic signed [STATE_WIDTH-1:0] last_in_reg [SectionCount];
    logic signed [STATE_WIDTH-1:0] last_out_reg [SectionCount];

    // Working registers.
    logic signed [SAMPLE_WIDTH-1:0] in_left_reg, in_right_reg;
    logic signed [STATE_WIDTH-1:0]  cur_reg, cur_next;
    logic signed [STATE_WIDTH-1:0]  dry_reg;
    logic signed [ProdWidth-1:0]    prod_reg;
    logic signed [AccWidth-1:0]     acc_reg, acc_next;
    logic signed [SAMPLE_WIDTH-1:0] stage_left_reg, stage_right_reg;
    logic signed [SAMPLE_WIDTH-1:0] left_result_reg, right_result_reg;

    logic [2:0]                    state_idx;
    logic [CfgWidth-1:0]           coef_set;
    logic signed [COEF_WIDTH-1:0]  coef_b0, coef_b1, coef_a1;
    logic signed [GAIN_WIDTH-1:0]  gain_drive, gain_trim, gain_mix, gain_level;
    logic signed [STATE_WIDTH-1:0] mul_a;
    logic signed [MulWidth-1:0]    mul_b;
    logic signed [ProdWidth-1:0]   prod_next;
    logic signed [AccWidth-1:0]    sec_rnd, gain_rnd, rnd_val, lim_val;
    logic signed [STATE_WIDTH-1:0] sat_val, mix_sat, in_ext;
    logic signed [SAMPLE_WIDTH-1:0] out_val;
    logic signed [STATE_WIDTH:0]   mix_sum;

    assign state_idx = {cmd.ch, cmd.sec};

    // Coefficient set of the active section.
    always_comb
    begin
        case (cmd.sec)
            SEC_HP:  coef_set = cmd.ch ? hp_right_reg : hp_left_reg;
            SEC_LP:  coef_set = cmd.ch ? lp_right_reg : lp_left_reg;
            SEC_LS:  coef_set = low_shelf_reg;
            SEC_HS:  coef_set = high_shelf_reg;
            default: coef_set = low_shelf_reg;
        endcase
    end

    assign coef_b0 = coef_set[3*COEF_WIDTH-1:2*COEF_WIDTH];
    assign coef_b1 = coef_set[2*COEF_WIDTH-1:COEF_WIDTH];
    assign coef_a1 = coef_set[COEF_WIDTH-1:0];
    assign gain_drive = drive_trim_reg[2*GAIN_WIDTH-1:GAIN_WIDTH];
    assign gain_trim = drive_trim_reg[GAIN_WIDTH-1:0];
    assign gain_mix = mix_level_reg[2*GAIN_WIDTH-1:GAIN_WIDTH];
    assign gain_level = mix_level_reg[GAIN_WIDTH-1:0];

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (cmd.a_sel)
            A_X1:    mul_a = last_in_reg[state_idx];
            A_Y1:    mul_a = last_out_reg[state_idx];
            default: mul_a = cur_reg;
        endcase
        case (cmd.b_sel)
            B_B0:    mul_b = MulWidth'(coef_b0);
            B_B1:    mul_b = MulWidth'(coef_b1);
            B_A1:    mul_b = MulWidth'(coef_a1);
            B_DRIVE: mul_b = MulWidth'(gain_drive);
            B_TRIM:  mul_b = MulWidth'(gain_trim);
            B_MIX:   mul_b = MulWidth'(gain_mix);
            B_LEVEL: mul_b = MulWidth'(gain_level);
            default: mul_b = MulWidth'(gain_level);
        endcase
    end

    assign prod_next = ProdWidth'(mul_a) * ProdWidth'(mul_b);

    // Accumulator for the three products of a section.
    always_comb
    begin
        case (cmd.acc_op)
            ACC_LOAD: acc_next = AccWidth'(prod_reg);
            ACC_ADD:  acc_next = acc_reg + AccWidth'(prod_reg);
            default:  acc_next = acc_reg;
        endcase
    end

    // Round half up back to the sample scale.
    assign sec_rnd = (acc_reg + SecHalf) >>> CoefFrac;
    assign gain_rnd = (AccWidth'(prod_reg) + GainHalf) >>> GAIN_FRAC;

    // Optional clamp to +-1, then state-range saturation; out_val saturates to sample range.
    always_comb
    begin
        rnd_val = (cmd.fin_op == FIN_SEC) ? sec_rnd : gain_rnd;
        lim_val = rnd_val;
        if (cmd.fin_op == FIN_CLAMP)
        begin
            if (rnd_val > OneVal)
                lim_val = OneVal;
            else if (rnd_val < NegOne)
                lim_val = NegOne;
        end
        if (lim_val > StateMax)
            sat_val = STATE_WIDTH'(StateMax);
        else if (lim_val < StateMin)
            sat_val = STATE_WIDTH'(StateMin);
        else
            sat_val = STATE_WIDTH'(lim_val);
        if (rnd_val > OutMax)
            out_val = SAMPLE_WIDTH'(OutMax);
        else if (rnd_val < NegOne)
            out_val = SAMPLE_WIDTH'(NegOne);
        else
            out_val = SAMPLE_WIDTH'(rnd_val);
    end

    // Dry plus wet sum, saturated.
    assign mix_sum = (STATE_WIDTH+1)'(dry_reg) + (STATE_WIDTH+1)'(cur_reg);
    always_comb
    begin
        if (mix_sum > SumMax)
            mix_sat = STATE_WIDTH'(SumMax);
        else if (mix_sum < SumMin)
            mix_sat = STATE_WIDTH'(SumMin);
        else
            mix_sat = STATE_WIDTH'(mix_sum);
    end

    // Next value of the running signal.
    assign in_ext = cmd.ch ? STATE_WIDTH'(in_right_reg) : STATE_WIDTH'(in_left_reg);
    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.load)
            cur_next = in_ext;
        case (cmd.fin_op)
            FIN_SEC, FIN_CLAMP, FIN_GAIN: cur_next = sat_val;
            FIN_MIX_ADD:                  cur_next = mix_sat;
            default:                      ;
        endcase
    end

    // Configuration and filter state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_left_reg <= '0;
            hp_right_reg <= '0;
            lp_left_reg <= '0;
            lp_right_reg <= '0;
            low_shelf_reg <= '0;
            high_shelf_reg <= '0;
            drive_trim_reg <= '0;
            mix_level_reg <= '0;
            for (int i = 0; i < SectionCount; i++)
            begin
                last_in_reg[i] <= '0;
                last_out_reg[i] <= '0;
            end
        end
        else
        begin
            if (write_enable)
            begin
                case (write_index)
                    REG_HP_LEFT:    hp_left_reg <= write_data;
                    REG_HP_RIGHT:   hp_right_reg <= write_data;
                    REG_LP_LEFT:    lp_left_reg <= write_data;
                    REG_LP_RIGHT:   lp_right_reg <= write_data;
                    REG_LOW_SHELF:  low_shelf_reg <= write_data;
                    REG_HIGH_SHELF: high_shelf_reg <= write_data;
                    REG_DRIVE_TRIM: drive_trim_reg <= write_data[2*GAIN_WIDTH-1:0];
                    REG_MIX_LEVEL:  mix_level_reg <= write_data[2*GAIN_WIDTH-1:0];
                    default:        ;
                endcase
            end
            if (cmd.fin_op == FIN_SEC)
            begin
                last_in_reg[state_idx] <= cur_reg;
                last_out_reg[state_idx] <= sat_val;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_left_reg <= left_sample;
            in_right_reg <= right_sample;
        end
        if (cmd.load)
            dry_reg <= in_ext;
        cur_reg <= cur_next;
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        if (cmd.fin_op == FIN_OUT)
        begin
            if (cmd.ch)
                stage_right_reg <= out_val;
            else
                stage_left_reg <= out_val;
        end
        if (cmd.publish)
        begin
            left_result_reg <= stage_left_reg;
            right_result_reg <= stage_right_reg;
        end
    end

    assign left_result = left_result_reg;
    assign right_result = right_result_reg;

endmodule

FILE: rtl/core/sefc_controller.sv
module sefc_controller
    import sefc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output sefc_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_ACC,
        ST_SFIN,
        ST_GMUL,
        ST_GFIN,
        ST_ADD,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_HP,
        PH_DRIVE,
        PH_TRIM,
        PH_LP,
        PH_MIX,
        PH_LS,
        PH_HS,
        PH_LEVEL
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   ch_reg, ch_next;
    logic   out_valid_reg, out_valid_next;
    logic   publish;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign publish = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Sequencing through the sections and gain steps of each channel.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        ch_next = ch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOAD;
                    ch_next = 1'b0;
                end
            end
            ST_LOAD:
            begin
                phase_next = PH_HP;
                state_next = ST_M0;
            end
            ST_M0:   state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_ACC;
            ST_ACC:  state_next = ST_SFIN;
            ST_SFIN:
            begin
                case (phase_reg)
                    PH_HP:
                    begin
                        phase_next = PH_DRIVE;
                        state_next = ST_GMUL;
                    end
                    PH_LP:
                    begin
                        phase_next = PH_MIX;
                        state_next = ST_GMUL;
                    end
                    PH_LS:
                    begin
                        phase_next = PH_HS;
                        state_next = ST_M0;
                    end
                    default:
                    begin
                        phase_next = PH_LEVEL;
                        state_next = ST_GMUL;
                    end
                endcase
            end
            ST_GMUL: state_next = ST_GFIN;
            ST_GFIN:
            begin
                case (phase_reg)
                    PH_DRIVE:
                    begin
                        phase_next = PH_TRIM;
                        state_next = ST_GMUL;
                    end
                    PH_TRIM:
                    begin
                        phase_next = PH_LP;
                        state_next = ST_M0;
                    end
                    PH_MIX:
                        state_next = ST_ADD;
                    default:
                    begin
                        if (ch_reg)
                            state_next = ST_DONE;
                        else
                        begin
                            ch_next = 1'b1;
                            state_next = ST_LOAD;
                        end
                    end
                endcase
            end
            ST_ADD:
            begin
                phase_next = PH_LS;
                state_next = ST_M0;
            end
            ST_DONE:
            begin
                if (publish)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        if (publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Command decode.
    always_comb
    begin
        cmd = '0;
        cmd.capture = in_valid && (state_reg == ST_IDLE);
        cmd.load = (state_reg == ST_LOAD);
        cmd.ch = ch_reg;
        cmd.publish = publish;
        cmd.a_sel = A_CUR;
        cmd.acc_op = ACC_HOLD;
        cmd.fin_op = FIN_NONE;
        case (phase_reg)
            PH_LP:   cmd.sec = SEC_LP;
            PH_LS:   cmd.sec = SEC_LS;
            PH_HS:   cmd.sec = SEC_HS;
            default: cmd.sec = SEC_HP;
        endcase
        case (phase_reg)
            PH_DRIVE: cmd.b_sel = B_DRIVE;
            PH_TRIM:  cmd.b_sel = B_TRIM;
            PH_MIX:   cmd.b_sel = B_MIX;
            default:  cmd.b_sel = B_LEVEL;
        endcase
        case (state_reg)
            ST_M0:
                cmd.b_sel = B_B0;
            ST_M1:
            begin
                cmd.a_sel = A_X1;
                cmd.b_sel = B_B1;
                cmd.acc_op = ACC_LOAD;
            end
            ST_M2:
            begin
                cmd.a_sel = A_Y1;
                cmd.b_sel = B_A1;
                cmd.acc_op = ACC_ADD;
            end
            ST_ACC:
                cmd.acc_op = ACC_ADD;
            ST_SFIN:
                cmd.fin_op = FIN_SEC;
            ST_GFIN:
            begin
                case (phase_reg)
                    PH_DRIVE: cmd.fin_op = FIN_CLAMP;
                    PH_LEVEL: cmd.fin_op = FIN_OUT;
                    default:  cmd.fin_op = FIN_GAIN;
                endcase
            end
            ST_ADD:
                cmd.fin_op = FIN_MIX_ADD;
            default: ;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_HP;
            ch_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ch_reg <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: tb/sv/stereo_enhancer_filter_chain_test.sv
module stereo_enhancer_filter_chain_test;
    import sefc_pkg::*;

    localparam int SW = 24;
    localparam int CW = 18;
    localparam int CF = CW - 2;
    localparam int RANDOM_FRAMES = 625;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 64;
    localparam longint UNITY = 64'sd1 <<< (SW - 1);

    // Handy coefficient (Q2.16), gain (Q4.14) and sample (Q1.23) codes.
    localparam logic [CW-1:0] COEF_ONE = 18'h10000;
    localparam logic [CW-1:0] COEF_NEG_ONE = 18'h30000;
    localparam logic [CW-1:0] WORD_MAX = 18'h1FFFF;
    localparam logic [CW-1:0] WORD_MIN = 18'h20000;
    localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = 18'h04000;
    localparam logic [SW-1:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam logic [SW-1:0] SAMPLE_MIN = 24'h800000;

    typedef struct packed {
        logic [SW-1:0] left;
        logic [SW-1:0] right;
    } stereo_frame_t;

    typedef struct packed {
        logic          is_write;
        cfg_index_t    idx;
        logic [3*CW-1:0] data;
        logic [SW-1:0] left;
        logic [SW-1:0] right;
        logic          typed;
        logic [SW-1:0] want_left;
        logic [SW-1:0] want_right;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic write_enable;
    cfg_index_t write_index;
    logic [3*CW-1:0] write_data;
    logic in_valid;
    logic in_ready;
    logic signed [SW-1:0] left_sample;
    logic signed [SW-1:0] right_sample;
    logic out_valid;
    logic out_ready;
    logic signed [SW-1:0] left_result;
    logic signed [SW-1:0] right_result;

    // Shadow copy of the registers and of the per-section filter history.
    logic [3*CW-1:0] reg_shadow [8];
    int last_in [8];
    int last_out [8];

    stereo_frame_t due_frames [$];
    stereo_frame_t head;
    stim_row_t directed_rows [$];

    int burst_left = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    int calm_left = 0;
    int mismatches = 0;
    int checked = 0;
    int directed_sent = 0;
    int random_sent = 0;
    int settings_count = 0;

    stereo_enhancer_filter_chain dut (
        .clk(clk),
        .rst_n(rst_n),
        .write_enable(write_enable),
        .write_index(write_index),
        .write_data(write_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .left_sample(left_sample),
        .right_sample(right_sample),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .left_result(left_result),
        .right_result(right_result)
    );

    always #10 clk = ~clk;

    // Fixed-point helpers of the predictor.
    function automatic longint saturate_to(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -(64'sd1 <<< (w - 1));
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Round half up: add half an LSB, then floor shift.
    function automatic longint scale_round(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // One first-order section: y = b0*x + b1*x1 + a1*y1, history updated.
    function automatic longint filter_step(input int slot, input logic [3*CW-1:0] c,
                                           input longint x);
        longint b0;
        longint b1;
        longint a1;
        longint acc;
        longint y;
        b0 = longint'($signed(c[3*CW-1:2*CW]));
        b1 = longint'($signed(c[2*CW-1:CW]));
        a1 = longint'($signed(c[CW-1:0]));
        acc = b0 * x + b1 * longint'(last_in[slot]) + a1 * longint'(last_out[slot]);
        y = saturate_to(scale_round(acc, CF), STATE_WIDTH);
        last_in[slot] = int'(x);
        last_out[slot] = int'(y);
        return y;
    endfunction

    function automatic longint gain_step(input longint x, input logic [GAIN_WIDTH-1:0] g);
        longint gv;
        gv = longint'($signed(g));
        return saturate_to(scale_round(x * gv, GAIN_FRAC), STATE_WIDTH);
    endfunction

    // Full enhancer chain for one channel (0 left, 1 right).
    function automatic logic [SW-1:0] enhance_channel(input int ch, input logic [SW-1:0] raw);
        int base;
        longint x;
        longint e;
        longint y;
        logic [3*CW-1:0] hp;
        logic [3*CW-1:0] lp;
        logic [2*GAIN_WIDTH-1:0] dt;
        logic [2*GAIN_WIDTH-1:0] ml;
        base = ch * 4;
        hp = reg_shadow[(ch == 0) ? REG_HP_LEFT : REG_HP_RIGHT];
        lp = reg_shadow[(ch == 0) ? REG_LP_LEFT : REG_LP_RIGHT];
        dt = reg_shadow[REG_DRIVE_TRIM][2*GAIN_WIDTH-1:0];
        ml = reg_shadow[REG_MIX_LEVEL][2*GAIN_WIDTH-1:0];
        x = longint'($signed(raw));
        e = gain_step(filter_step(base + SEC_HP, hp, x), dt[2*GAIN_WIDTH-1:GAIN_WIDTH]);
        if (e > UNITY)
            e = UNITY;
        if (e < -UNITY)
            e = -UNITY;
        e = gain_step(e, dt[GAIN_WIDTH-1:0]);
        e = filter_step(base + SEC_LP, lp, e);
        y = saturate_to(x + gain_step(e, ml[2*GAIN_WIDTH-1:GAIN_WIDTH]), STATE_WIDTH);
        y = filter_step(base + SEC_LS, reg_shadow[REG_LOW_SHELF], y);
        y = filter_step(base + SEC_HS, reg_shadow[REG_HIGH_SHELF], y);
        y = saturate_to(scale_round(y * longint'($signed(ml[GAIN_WIDTH-1:0])), GAIN_FRAC), SW);
        return y[SW-1:0];
    endfunction

    // Directed table builders.
    function automatic void add_write(input cfg_index_t idx, input logic [3*CW-1:0] data);
        stim_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.idx = idx;
        r.data = data;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_frame(input logic [SW-1:0] l, input logic [SW-1:0] rt);
        stim_row_t r;
        r = '0;
        r.left = l;
        r.right = rt;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_typed(input logic [SW-1:0] l, input logic [SW-1:0] rt,
                                      input logic [SW-1:0] el, input logic [SW-1:0] er);
        stim_row_t r;
        r = '0;
        r.left = l;
        r.right = rt;
        r.typed = 1'b1;
        r.want_left = el;
        r.want_right = er;
        directed_rows.push_back(r);
    endfunction

    // Random word: 0 extremes, 1 any code, otherwise a tame value within +-span.
    function automatic logic [CW-1:0] pick_word(input int kind, input int span,
                                               input logic [CW-1:0] unit);
        int v;
        if (kind == 0)
        begin
            case ($urandom_range(0, 4))
                0: return '0;
                1: return WORD_MAX;
                2: return WORD_MIN;
                3: return unit;
                default: return -unit;
            endcase
        end
        if (kind == 1)
            return CW'($urandom);
        v = int'($urandom_range(0, 2 * span)) - span;
        return v[CW-1:0];
    endfunction

    function automatic logic [SW-1:0] random_sample();
        int v;
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return '0;
                    3: return 24'h000001;
                    default: return 24'hFFFFFF;
                endcase
            end
            1:
            begin
                v = int'($urandom_range(0, 2048)) - 1024;
                return v[SW-1:0];
            end
            default: return SW'($urandom);
        endcase
    endfunction

    // Stop sending and wait until every frame in flight has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (due_frames.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write; a first write after frames waits for the block to go idle.
    task automatic write_reg(input cfg_index_t idx, input logic [3*CW-1:0] data);
        if (!write_enable)
            drain();
        write_enable <= 1'b1;
        write_index <= idx;
        write_data <= data;
        @(negedge clk);
        if (idx == REG_DRIVE_TRIM || idx == REG_MIX_LEVEL)
            reg_shadow[idx] = data[2*GAIN_WIDTH-1:0];
        else
            reg_shadow[idx] = data;
    endtask

    // Write all eight registers for one random setting.
    task automatic configure_random(input int style);
        cfg_index_t idx;
        int kind;
        logic [GAIN_WIDTH-1:0] spare;
        for (int i = 0; i < 8; i++)
        begin
            idx = cfg_index_t'(i);
            kind = (style >= 2) ? (($urandom_range(0, 5) == 0) ? 1 : 2) : style;
            spare = GAIN_WIDTH'($urandom);
            if (idx == REG_DRIVE_TRIM || idx == REG_MIX_LEVEL)
                write_reg(idx, {spare, pick_word(kind, 32768, GAIN_ONE),
                                pick_word(kind, 32768, GAIN_ONE)});
            else
                write_reg(idx, {pick_word(kind, 49152, COEF_ONE),
                                pick_word(kind, 49152, COEF_ONE),
                                pick_word(kind, 49152, COEF_ONE)});
        end
    endtask

    // Send one frame in bursts with random gaps; record its expected result on acceptance.
    task automatic send_frame(input logic [SW-1:0] l, input logic [SW-1:0] r, input logic typed,
                              input logic [SW-1:0] el, input logic [SW-1:0] er);
        stereo_frame_t want;
        int gap;
        write_enable <= 1'b0;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                      : $urandom_range(1, 6);
        end
        burst_left--;
        in_valid <= 1'b1;
        left_sample <= l;
        right_sample <= r;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        want.left = enhance_channel(0, l);
        want.right = enhance_channel(1, r);
        if (typed)
        begin
            want.left = el;
            want.right = er;
        end
        due_frames.push_back(want);
        @(negedge clk);
    endtask

    // Receiver: mostly ready, with short and long stalls and calm stretches.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 7) == 0)
            begin
                stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                         : $urandom_range(1, 10);
                calm_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 600) : 0;
            end
        end
    end

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                checked++;
                if (due_frames.size() == 0)
                begin
                    $display("%0t: result beat with no frame outstanding: left %0d right %0d",
                             $time, left_result, right_result);
                    mismatches++;
                end
                else
                begin
                    head = due_frames.pop_front();
                    if (left_result !== head.left)
                    begin
                        $display("%0t: left_result expected %0d got %0d", $time,
                                 $signed(head.left), left_result);
                        mismatches++;
                    end
                    if (right_result !== head.right)
                    begin
                        $display("%0t: right_result expected %0d got %0d", $time,
                                 $signed(head.right), right_result);
                        mismatches++;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: no beat for %0d cycles, %0d frames outstanding", $time,
                             QUIET_LIMIT, due_frames.size());
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        stim_row_t row;
        int phase_len;

        rst_n = 1'b0;
        write_enable = 1'b0;
        write_index = REG_HP_LEFT;
        write_data = '0;
        in_valid = 1'b0;
        left_sample = '0;
        right_sample = '0;
        out_ready = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            reg_shadow[i] = '0;
            last_in[i] = 0;
            last_out[i] = 0;
        end

        // Every gain is zero after reset, so the output is silent.
        add_typed(SAMPLE_MAX, SAMPLE_MIN, '0, '0);
        add_typed(SAMPLE_MIN, SAMPLE_MAX, '0, '0);
        add_typed(24'h000001, 24'hFFFFFF, '0, '0);
        // Unity shelves and unity level with a silent wet path pass the dry sample through.
        add_write(REG_LOW_SHELF, {COEF_ONE, {CW{1'b0}}, {CW{1'b0}}});
        add_write(REG_HIGH_SHELF, {COEF_ONE, {CW{1'b0}}, {CW{1'b0}}});
        add_write(REG_MIX_LEVEL, {{CW{1'b0}}, {GAIN_WIDTH{1'b0}}, GAIN_ONE});
        add_typed(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
        add_typed(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);
        add_typed(24'h000000, 24'h000001, 24'h000000, 24'h000001);
        // Level of -8 saturates the output at both rails.
        add_write(REG_MIX_LEVEL, {{CW{1'b0}}, {GAIN_WIDTH{1'b0}}, WORD_MIN});
        add_typed(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX);
        add_typed(24'h000000, 24'h000001, 24'h000000, 24'hFFFFF8);
        // Largest level exercises output rounding.
        add_write(REG_MIX_LEVEL, {{CW{1'b1}}, {GAIN_WIDTH{1'b0}}, WORD_MAX});
        add_frame(24'h000001, 24'hFFFFFF);
        add_frame(24'h000100, 24'hFFFF00);
        // Whole chain live, drive at its top so the clamp engages.
        add_write(REG_HP_LEFT, {COEF_ONE, COEF_NEG_ONE, 18'h0F333});
        add_write(REG_HP_RIGHT, {18'h08000, 18'h38000, 18'h0E000});
        add_write(REG_LP_LEFT, {18'h04000, 18'h04000, 18'h08000});
        add_write(REG_LP_RIGHT, {WORD_MAX, WORD_MAX, WORD_MIN});
        add_write(REG_LOW_SHELF, {18'h12000, 18'h3E000, 18'h06000});
        add_write(REG_HIGH_SHELF, {18'h0C000, 18'h02000, 18'h3C000});
        add_write(REG_DRIVE_TRIM, {{CW{1'b1}}, WORD_MAX, GAIN_ONE});
        add_write(REG_MIX_LEVEL, {{CW{1'b0}}, GAIN_ONE, GAIN_ONE});
        add_frame(SAMPLE_MAX, SAMPLE_MIN);
        add_frame(SAMPLE_MAX, SAMPLE_MIN);
        add_frame(SAMPLE_MIN, SAMPLE_MAX);
        add_frame(24'h000000, 24'h000000);
        add_frame(24'h400000, 24'hC00000);
        add_frame(24'h000001, 24'hFFFFFF);
        add_frame(SAMPLE_MAX, SAMPLE_MAX);
        add_frame(SAMPLE_MIN, SAMPLE_MIN);
        // Runaway low shelf drives the internal state into 32-bit saturation.
        add_write(REG_LOW_SHELF, {WORD_MAX, {CW{1'b0}}, WORD_MAX});
        for (int i = 0; i < 7; i++)
            add_frame(SAMPLE_MAX, SAMPLE_MAX);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table.
        for (int i = 0; i < directed_rows.size(); i++)
        begin
            row = directed_rows[i];
            if (row.is_write)
                write_reg(row.idx, row.data);
            else
            begin
                send_frame(row.left, row.right, row.typed, row.want_left, row.want_right);
                directed_sent++;
            end
        end
        settings_count = 5;

        // Random phases, each under a fresh register setting.
        while (random_sent < RANDOM_FRAMES)
        begin
            configure_random($urandom_range(0, 3));
            settings_count++;
            phase_len = $urandom_range(30, 90);
            if (phase_len > RANDOM_FRAMES - random_sent)
                phase_len = RANDOM_FRAMES - random_sent;
            repeat (phase_len)
            begin
                send_frame(random_sample(), random_sample(), 1'b0, '0, '0);
                random_sent++;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d directed and %0d random frames under %0d register settings.",
                 directed_sent, random_sent, settings_count);
        $display("Checked %0d result beats, %0d mismatches.", checked, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: stereo_enhancer_filter_chain.f
rtl/core/sefc_pkg.sv
rtl/core/sefc_datapath.sv
rtl/core/sefc_controller.sv
rtl/core/stereo_enhancer_filter_chain.sv
tb/sv/stereo_enhancer_filter_chain_test.sv
